// ===== src/audio_loop_repeater_macros.svh =====
// Assertion shorthands for the loop repeater; clock and reset are passed in.
`ifndef AUDIO_LOOP_REPEATER_MACROS_SVH
`define AUDIO_LOOP_REPEATER_MACROS_SVH

// Check a condition on every enabled clock edge.
`define ALR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ALR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/alr_pkg.sv =====
package alr_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTICLICK = 3'd4;

  // Register widths
  localparam int VOLUME_W    = 9;
  localparam int LOOP_LEN_W  = 15;
  localparam int REPEATS_W   = 7;
  localparam int ANTICLICK_W = 8;

  // Register reset values
  localparam logic [VOLUME_W-1:0]    VOLUME_RST    = 9'd256;
  localparam logic [LOOP_LEN_W-1:0]  LOOP_LEN_RST  = 15'd16384;
  localparam logic [REPEATS_W-1:0]   REPEATS_RST   = 7'd0;
  localparam logic                   STEREO_RST    = 1'b1;
  localparam logic [ANTICLICK_W-1:0] ANTICLICK_RST = 8'd44;

  // Crossfade weight: 8-bit quotient, one bit per divider step
  localparam int WEIGHT_W = 8;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL_S,
    ST_MUL_T,
    ST_SUM,
    ST_VOL,
    ST_SAT,
    ST_FINISH
  } alr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic div_step;
    logic mul_s;
    logic mul_t;
    logic sum;
    logic vol;
    logic sat;
    logic emit;
  } alr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mute;
    logic fade;
    logic div_last;
    logic ch_last;
    logic out_full;
  } alr_status_t;

endpackage

// ===== src/alr_in_if.sv =====
interface alr_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_in;
  logic signed [W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== src/alr_out_if.sv =====
interface alr_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_out;
  logic signed [W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/alr_ctrl.sv =====
module alr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alr_pkg::alr_status_t status,
  output alr_pkg::alr_cmd_t    cmd
);
  import alr_pkg::*;

  alr_state_t state_r, state_nxt;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (status.mute) state_nxt = ST_FINISH;
        else if (status.fade) state_nxt = ST_DIV;
        else state_nxt = ST_SUM;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_MUL_S;
      end
      ST_MUL_S: state_nxt = ST_MUL_T;
      ST_MUL_T: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_VOL;
      ST_VOL:   state_nxt = ST_SAT;
      ST_SAT: begin
        if (status.ch_last) state_nxt = ST_FINISH;
        else if (status.fade) state_nxt = ST_MUL_S;
        else state_nxt = ST_SUM;
      end
      ST_FINISH: begin
        if (!status.out_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_START:  cmd.start    = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MUL_S:  cmd.mul_s    = 1'b1;
      ST_MUL_T:  cmd.mul_t    = 1'b1;
      ST_SUM:    cmd.sum      = 1'b1;
      ST_VOL:    cmd.vol      = 1'b1;
      ST_SAT:    cmd.sat      = 1'b1;
      ST_FINISH: cmd.emit     = !status.out_full;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/alr_datapath.sv =====
module alr_datapath #(
  parameter int MAX_LOOP    = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  alr_pkg::alr_cmd_t                  cmd,
  output alr_pkg::alr_status_t               status,
  input  logic signed [SAMPLE_BITS-1:0]      left_in,
  input  logic signed [SAMPLE_BITS-1:0]      right_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  input  logic                               cfg_we,
  input  logic [alr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import alr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PB = $clog2(MAX_LOOP);
  localparam int AW = SB + 1;
  localparam int PW = AW + 10;
  localparam logic [31:0] MAX_L = 32'(MAX_LOOP);
  localparam logic signed [PW-1:0] SAT_HI = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers
  logic [VOLUME_W-1:0]    volume_r;
  logic [LOOP_LEN_W-1:0]  loop_len_r;
  logic [REPEATS_W-1:0]   repeats_r;
  logic                   stereo_r;
  logic [ANTICLICK_W-1:0] anticlick_r;

  // Loop state
  logic [PB-1:0]          pos_r;
  logic [REPEATS_W-1:0]   pass_r;
  logic signed [SB-1:0]   tail_l_r, tail_r_r;

  // Item working registers
  logic signed [SB-1:0]   in_l_r, in_r_r;
  logic signed [SB-1:0]   rd_l_r, rd_r_r;
  logic signed [SB-1:0]   res_l_r, res_r_r;
  logic [WEIGHT_W-1:0]    rem_r, q_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   ch_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [AW-1:0]   acc_r;

  // Output register
  logic                   out_valid_r;
  logic signed [SB-1:0]   out_l_r, out_r_r;

  // Stores
  logic signed [SB-1:0]   left_mem  [MAX_LOOP];
  logic signed [SB-1:0]   right_mem [MAX_LOOP];

  // Derived control
  logic [31:0] pos32, len32, eff_len;
  logic        rec, last, fade, mem_we_l, mem_we_r;
  logic [REPEATS_W:0] pass_inc;

  assign pos32   = 32'(pos_r);
  assign len32   = 32'(loop_len_r);
  assign eff_len = (len32 == 32'd0) ? 32'd1 : ((len32 > MAX_L) ? MAX_L : len32);
  assign last    = (pos32 == eff_len - 32'd1);
  assign rec     = (pass_r == '0);
  assign fade    = !rec && (anticlick_r != '0) && (pos32 < 32'(anticlick_r));
  assign pass_inc = {1'b0, pass_r} + (REPEATS_W+1)'(1);
  assign mem_we_l = cmd.start && (volume_r != '0) && rec;
  assign mem_we_r = mem_we_l && stereo_r;

  assign status.mute     = (volume_r == '0);
  assign status.fade     = fade;
  assign status.div_last = (cnt_r == DIV_LAST);
  assign status.ch_last  = ch_r;
  assign status.out_full = out_valid_r && !out_ready;

  // Write and read the left store
  always_ff @(posedge clk) begin
    if (mem_we_l) left_mem[pos_r] <= in_l_r;
    if (cmd.start) rd_l_r <= left_mem[pos_r];
  end

  // Write and read the right store
  always_ff @(posedge clk) begin
    if (mem_we_r) right_mem[pos_r] <= in_r_r;
    if (cmd.start) rd_r_r <= right_mem[pos_r];
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_l_r <= left_in;
      in_r_r <= right_in;
    end
  end

  // Configuration, position, pass count and tails
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r    <= VOLUME_RST;
      loop_len_r  <= LOOP_LEN_RST;
      repeats_r   <= REPEATS_RST;
      stereo_r    <= STEREO_RST;
      anticlick_r <= ANTICLICK_RST;
      pos_r       <= '0;
      pass_r      <= '0;
      tail_l_r    <= '0;
      tail_r_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOLUME: volume_r <= cfg_data[VOLUME_W-1:0];
        CFG_LOOP_LEN: begin
          loop_len_r <= cfg_data[LOOP_LEN_W-1:0];
          pos_r      <= '0;
          pass_r     <= '0;
        end
        CFG_REPEATS: begin
          repeats_r <= cfg_data[REPEATS_W-1:0];
          pos_r     <= '0;
          pass_r    <= '0;
        end
        CFG_STEREO:    stereo_r    <= cfg_data[0];
        CFG_ANTICLICK: anticlick_r <= cfg_data[ANTICLICK_W-1:0];
        default: ;
      endcase
    end else begin
      // Take the tails when recording the last sample of the segment
      if (mem_we_l && last) tail_l_r <= in_l_r;
      if (mem_we_r && last) tail_r_r <= in_r_r;
      // Advance position and pass once the beat leaves
      if (cmd.emit && (volume_r != '0)) begin
        if (last) begin
          pos_r  <= '0;
          pass_r <= (pass_inc > {1'b0, repeats_r}) ? '0 : pass_inc[REPEATS_W-1:0];
        end else begin
          pos_r <= PB'(pos32 + 32'd1);
        end
      end
    end
  end

  // Restoring divider for the crossfade weight
  logic [WEIGHT_W:0] rem_sh;
  assign rem_sh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= pos32[WEIGHT_W-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, anticlick_r}) begin
        rem_r <= WEIGHT_W'(rem_sh - {1'b0, anticlick_r});
        q_r   <= {q_r[WEIGHT_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WEIGHT_W-1:0];
        q_r   <= {q_r[WEIGHT_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  // Channel operands
  logic signed [SB-1:0] sample_c, tail_c;
  assign sample_c = rec ? (ch_r ? in_r_r : in_l_r) : (ch_r ? rd_r_r : rd_l_r);
  assign tail_c   = ch_r ? tail_r_r : tail_l_r;

  // Shared multiplier operand select
  logic signed [AW-1:0] mul_a;
  logic signed [9:0]    mul_b;
  logic [8:0]           inv_w;
  logic signed [PW-1:0] prod_c;

  assign inv_w = 9'd256 - {1'b0, q_r};

  always_comb begin
    mul_a = acc_r;
    mul_b = '0;
    if (cmd.mul_s) begin
      mul_a = AW'(sample_c);
      mul_b = $signed({2'b00, q_r});
    end else if (cmd.mul_t) begin
      mul_a = AW'(tail_c);
      mul_b = $signed({1'b0, inv_w});
    end else if (cmd.vol) begin
      mul_a = acc_r;
      mul_b = $signed({1'b0, volume_r});
    end
  end

  assign prod_c = mul_a * mul_b;

  // Divide the product by 256, rounding toward zero
  logic signed [PW-1:0] bias_c, biased_c, div_c;
  assign bias_c   = $signed({{(PW-8){1'b0}}, prod_r[PW-1] ? 8'hFF : 8'h00});
  assign biased_c = prod_r + bias_c;
  assign div_c    = biased_c >>> 8;

  // Saturate to the sample range
  logic signed [SB-1:0] sat_c;
  assign sat_c = (div_c > SAT_HI) ? SAT_HI[SB-1:0] :
                 ((div_c < SAT_LO) ? SAT_LO[SB-1:0] : div_c[SB-1:0]);

  // Multiply, accumulate and saturate one channel at a time
  always_ff @(posedge clk) begin
    if (cmd.mul_s || cmd.mul_t || cmd.vol) prod_r <= prod_c;
    if (cmd.mul_t) acc_r <= AW'(div_c);
    if (cmd.sum) acc_r <= fade ? AW'(acc_r + AW'(div_c)) : AW'(sample_c);
    if (cmd.sat) begin
      if (ch_r) res_r_r <= sat_c;
      else      res_l_r <= sat_c;
    end
  end

  // Channel select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= 1'b0;
    end else if (cmd.start) begin
      ch_r <= 1'b0;
    end else if (cmd.sat) begin
      ch_r <= 1'b1;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (volume_r == '0) begin
        out_l_r <= '0;
        out_r_r <= '0;
      end else begin
        out_l_r <= res_l_r;
        out_r_r <= stereo_r ? res_r_r : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign left_out  = out_l_r;
  assign right_out = out_r_r;

endmodule

// ===== src/audio_loop_repeater.sv =====
// Stereo loop repeater. Each input beat is one stereo frame and gives exactly
// one output beat. A recording pass writes frames into two on-chip loop stores
// and passes them through; the segment is then replayed "repeats" times with a
// crossfade from the segment's last sample over the first samples of each
// replay (as many as the crossfade length register gives), and all output is
// scaled by volume/256 with saturation. Frames are handled one at a time by a
// sequencer driving a single shared multiplier and an 8-step divider for the
// crossfade weight, and a new frame is accepted only once the sequencer is back in
// idle; an output beat still waiting in the output register does not block the
// next acceptance, only the final write of that next item. The stores are not
// cleared after reset; they are defined wherever the recording pass has
// written them.
`include "audio_loop_repeater_macros.svh"

module audio_loop_repeater #(
  parameter int MAX_LOOP    = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  alr_in_if.sink                         in_beat,
  alr_out_if.source                      out_beat,
  input  logic                           cfg_we,
  input  logic [alr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alr_pkg::*;

  alr_cmd_t    cmd;
  alr_status_t status;
  logic        in_ready;

  assign in_beat.ready = in_ready;

  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  alr_datapath #(
    .MAX_LOOP    (MAX_LOOP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .left_in   (in_beat.left_in),
    .right_in  (in_beat.right_in),
    .out_valid (out_beat.valid),
    .out_ready (out_beat.ready),
    .left_out  (out_beat.left_out),
    .right_out (out_beat.right_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The sequencer issues one command at a time
  `ALR_ASSERT_ALWAYS(a_one_cmd, clk, rst_n, $onehot0(cmd), "more than one command active")

  // An accepted beat is started on the next cycle
  `ALR_ASSERT_NEXT(a_accept_start, clk, rst_n, in_beat.valid && in_ready, cmd.start && !in_ready, "accepted beat not started")

  // A result never overwrites one still waiting at the output
  `ALR_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.emit, !(out_beat.valid && !out_beat.ready), "pending output beat overwritten")

endmodule
